[design/lcdc_pkg.sv]
// Package for the LCD command and frame memory controller.
// Holds the sequencer state type, command codes and panel constants.
`timescale 1ns / 1ps
package lcdc_pkg;

  localparam int unsigned PanelWidth  = 240;
  localparam int unsigned PanelHeight = 320;
  localparam int unsigned FrameSize   = PanelWidth * PanelHeight;
  localparam int unsigned AddrW       = $clog2(FrameSize);

  localparam logic [23:0] DisplayIdReset = 24'h858552;

  localparam logic [15:0] CmdSwReset = 16'h0001;
  localparam logic [15:0] CmdRdId    = 16'h0004;
  localparam logic [15:0] CmdRdSt    = 16'h0009;
  localparam logic [15:0] CmdRdPwr   = 16'h000A;
  localparam logic [15:0] CmdRdMad   = 16'h000B;
  localparam logic [15:0] CmdRdFmt   = 16'h000C;
  localparam logic [15:0] CmdRdImg   = 16'h000D;
  localparam logic [15:0] CmdRdSig   = 16'h000E;
  localparam logic [15:0] CmdRdDiag  = 16'h000F;
  localparam logic [15:0] CmdSlpIn   = 16'h0010;
  localparam logic [15:0] CmdSlpOut  = 16'h0011;
  localparam logic [15:0] CmdPtlOn   = 16'h0012;
  localparam logic [15:0] CmdNorOn   = 16'h0013;
  localparam logic [15:0] CmdInvOff  = 16'h0020;
  localparam logic [15:0] CmdInvOn   = 16'h0021;
  localparam logic [15:0] CmdDispOff = 16'h0028;
  localparam logic [15:0] CmdDispOn  = 16'h0029;
  localparam logic [15:0] CmdCaSet   = 16'h002A;
  localparam logic [15:0] CmdRaSet   = 16'h002B;
  localparam logic [15:0] CmdRamWr   = 16'h002C;
  localparam logic [15:0] CmdRamRd   = 16'h002E;
  localparam logic [15:0] CmdTeOff   = 16'h0034;
  localparam logic [15:0] CmdTeOn    = 16'h0035;
  localparam logic [15:0] CmdMadCtl  = 16'h0036;
  localparam logic [15:0] CmdIdmOff  = 16'h0038;
  localparam logic [15:0] CmdIdmOn   = 16'h0039;
  localparam logic [15:0] CmdColMod  = 16'h003A;

  localparam logic [1:0] ActCmdWr  = 2'd0;
  localparam logic [1:0] ActDataWr = 2'd1;
  localparam logic [1:0] ActCmdRd  = 2'd2;
  localparam logic [1:0] ActDataRd = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE, S_ID1, S_ID2, S_ID3, S_ID4, S_ST1, S_ST2, S_ST3, S_ST4, S_ST5,
    S_PWR1, S_PWR2, S_MAD1, S_MAD2, S_FMT1, S_FMT2, S_IMG1, S_IMG2,
    S_SIG1, S_SIG2, S_DIAG1, S_DIAG2, S_COL1, S_COL2, S_COL3, S_COL4,
    S_ROW1, S_ROW2, S_ROW3, S_ROW4, S_WMAD, S_WFMT, S_MEMW, S_MEMR
  } seq_state_t;

  // Controller phases.
  typedef enum logic [2:0] {
    C_CLEAR, C_IDLE, C_EXEC, C_RD1, C_RD2, C_OUT
  } ctl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clr_step;   // write zero at clear address, advance it
    logic capture;    // latch the input item
    logic exec;       // apply item to registers, issue first RAM read
    logic rd1;        // first RAM data valid, issue second read
    logic rd2;        // second RAM data valid, finish
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic needs_rd;   // item is a memory data read
  } dp_sts_t;

endpackage

[design/lcdc_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lcdc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One access per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/lcdc_ctrl.sv]
// Controller state machine for the LCD controller.
// Uses lcdc_pkg; drives the datapath by command struct.
`timescale 1ns / 1ps
module lcdc_ctrl
  import lcdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_CLEAR: if (sts.clr_done) state_nxt = C_IDLE;
      C_IDLE:  if (in_valid) state_nxt = C_EXEC;
      C_EXEC:  state_nxt = sts.needs_rd ? C_RD1 : C_OUT;
      C_RD1:   state_nxt = C_RD2;
      C_RD2:   state_nxt = C_OUT;
      C_OUT:   if (!out_stall) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      C_CLEAR: cmd.clr_step = 1'b1;
      C_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      C_EXEC:  cmd.exec = 1'b1;
      C_RD1:   cmd.rd1 = 1'b1;
      C_RD2:   cmd.rd2 = 1'b1;
      C_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

[design/lcdc_dp.sv]
// Datapath of the LCD controller: registers, cursor, address map, frame RAM.
// Uses lcdc_pkg and lcdc_ram.
`timescale 1ns / 1ps
module lcdc_dp
  import lcdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_data_value,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic [15:0] out_read_data,
  output logic        out_pixel_written,
  output logic [16:0] out_pixel_index,
  output logic [15:0] out_pixel_color
);

  logic [23:0] id_r;
  seq_state_t  seq_r, seq_nxt;
  logic slp_r, ptl_r, nor_r, idm_r, inv_r, dis_r, te_r;
  logic slp_nxt, ptl_nxt, nor_nxt, idm_nxt, inv_nxt, dis_nxt, te_nxt;
  logic [5:0]  mad_r, mad_nxt;
  logic [2:0]  cfmt_r, cfmt_nxt, ifmt_r, ifmt_nxt;
  logic [15:0] cs_r, ce_r, rs_r, re_r, cs_nxt, ce_nxt, rs_nxt, re_nxt;
  logic [15:0] cc_r, cr_r, cc_nxt, cr_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [1:0]  act_r;
  logic [15:0] val_r;
  logic [AddrW-1:0] clr_r;
  // Memory read bookkeeping: which byte lanes each RAM read feeds.
  logic        a_ok_r, b_ok_r, a_ok_nxt, b_ok_nxt;
  logic [AddrW-1:0] b_idx_r, b_idx_nxt;
  logic [1:0]  rph_r, rph_nxt;
  logic [15:0] pa_r;
  logic [15:0] rd_r, rd_nxt;
  logic        pw_r, pw_nxt;
  logic [16:0] pi_r, pi_nxt;
  logic [15:0] pc_r, pc_nxt;

  logic        ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;

  // Address map of a cursor position.
  function automatic logic [AddrW:0] locate(input logic [15:0] c, input logic [15:0] r,
                                            input logic [5:0] mad);
    logic signed [17:0] x, y;
    logic [AddrW:0] res;
    res = '0;
    if (mad[3]) begin
      x = mad[5] ? $signed({2'b0, r}) : 18'(PanelWidth - 1) - $signed({2'b0, r});
      y = mad[4] ? $signed({2'b0, c}) : 18'(PanelHeight - 1) - $signed({2'b0, c});
    end else begin
      x = mad[4] ? 18'(PanelWidth - 1) - $signed({2'b0, c}) : $signed({2'b0, c});
      y = mad[5] ? 18'(PanelHeight - 1) - $signed({2'b0, r}) : $signed({2'b0, r});
    end
    if (x >= 0 && x < 18'(PanelWidth) && y >= 0 && y < 18'(PanelHeight)) begin
      res = {1'b1, AddrW'(y[9:0] * 10'(PanelWidth) + {7'b0, x[9:0]})};
    end
    return res;
  endfunction

  lcdc_ram #(.Width(16), .Depth(FrameSize)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Cursor step helpers.
  logic [15:0] adv_c, adv_r;
  always_comb begin
    if ({1'b0, cc_r} + 17'd1 > {1'b0, ce_r}) begin
      adv_c = cs_r;
      adv_r = ({1'b0, cr_r} + 17'd1 > {1'b0, re_r}) ? rs_r : cr_r + 16'd1;
    end else begin
      adv_c = cc_r + 16'd1;
      adv_r = cr_r;
    end
  end

  logic [AddrW:0] loc_cur, loc_adv;
  assign loc_cur = locate(cc_r, cr_r, mad_r);
  assign loc_adv = locate(adv_c, adv_r, mad_r);

  assign sts.clr_done = (clr_r == AddrW'(FrameSize - 1));
  assign sts.needs_rd = (act_r == ActDataRd) && (seq_r == S_MEMR);

  // Item execution: next values of the register file.
  always_comb begin
    seq_nxt = seq_r; slp_nxt = slp_r; ptl_nxt = ptl_r; nor_nxt = nor_r;
    idm_nxt = idm_r; inv_nxt = inv_r; dis_nxt = dis_r; te_nxt = te_r;
    mad_nxt = mad_r; cfmt_nxt = cfmt_r; ifmt_nxt = ifmt_r;
    cs_nxt = cs_r; ce_nxt = ce_r; rs_nxt = rs_r; re_nxt = re_r;
    cc_nxt = cc_r; cr_nxt = cr_r; ph_nxt = ph_r;
    rd_nxt = '0; pw_nxt = 1'b0; pi_nxt = '0; pc_nxt = '0;
    a_ok_nxt = a_ok_r; b_ok_nxt = b_ok_r; b_idx_nxt = b_idx_r; rph_nxt = rph_r;
    ram_we = 1'b0; ram_addr = clr_r; ram_wdata = '0;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end
    if (cmd.exec) begin
      case (act_r)
        ActCmdWr: begin
          case (val_r)
            CmdSwReset: begin
              slp_nxt = 1'b0; ptl_nxt = 1'b0; nor_nxt = 1'b1; idm_nxt = 1'b0;
              inv_nxt = 1'b0; dis_nxt = 1'b0; te_nxt = 1'b0;
              cs_nxt = '0; rs_nxt = '0;
              ce_nxt = mad_r[3] ? 16'(PanelHeight - 1) : 16'(PanelWidth - 1);
              re_nxt = mad_r[3] ? 16'(PanelWidth - 1) : 16'(PanelHeight - 1);
              seq_nxt = S_IDLE;
            end
            CmdRdId:   seq_nxt = S_ID1;
            CmdRdSt:   seq_nxt = S_ST1;
            CmdRdPwr:  seq_nxt = S_PWR1;
            CmdRdMad:  seq_nxt = S_MAD1;
            CmdRdFmt:  seq_nxt = S_FMT1;
            CmdRdImg:  seq_nxt = S_IMG1;
            CmdRdSig:  seq_nxt = S_SIG1;
            CmdRdDiag: seq_nxt = S_DIAG1;
            CmdSlpIn:  slp_nxt = 1'b0;
            CmdSlpOut: slp_nxt = 1'b1;
            CmdPtlOn: begin ptl_nxt = 1'b1; nor_nxt = 1'b0; end
            CmdNorOn: begin nor_nxt = 1'b1; ptl_nxt = 1'b0; end
            CmdInvOff: inv_nxt = 1'b0;
            CmdInvOn:  inv_nxt = 1'b1;
            CmdDispOff: dis_nxt = 1'b0;
            CmdDispOn: dis_nxt = 1'b1;
            CmdCaSet:  seq_nxt = S_COL1;
            CmdRaSet:  seq_nxt = S_ROW1;
            CmdRamWr: begin seq_nxt = S_MEMW; cc_nxt = cs_r; cr_nxt = rs_r; end
            CmdRamRd: begin
              seq_nxt = S_MEMR; cc_nxt = cs_r; cr_nxt = rs_r; ph_nxt = 2'd0;
            end
            CmdTeOff:  te_nxt = 1'b0;
            CmdTeOn:   te_nxt = 1'b1;
            CmdMadCtl: seq_nxt = S_WMAD;
            CmdIdmOff: idm_nxt = 1'b0;
            CmdIdmOn:  idm_nxt = 1'b1;
            CmdColMod: seq_nxt = S_WFMT;
            default: ;
          endcase
        end
        ActDataWr: begin
          case (seq_r)
            S_COL1: begin cs_nxt = {val_r[7:0], cs_r[7:0]}; seq_nxt = S_COL2; end
            S_COL2: begin cs_nxt = {cs_r[15:8], val_r[7:0]}; seq_nxt = S_COL3; end
            S_COL3: begin ce_nxt = {val_r[7:0], ce_r[7:0]}; seq_nxt = S_COL4; end
            S_COL4: begin ce_nxt = {ce_r[15:8], val_r[7:0]}; seq_nxt = S_IDLE; end
            S_ROW1: begin rs_nxt = {val_r[7:0], rs_r[7:0]}; seq_nxt = S_ROW2; end
            S_ROW2: begin rs_nxt = {rs_r[15:8], val_r[7:0]}; seq_nxt = S_ROW3; end
            S_ROW3: begin re_nxt = {val_r[7:0], re_r[7:0]}; seq_nxt = S_ROW4; end
            S_ROW4: begin re_nxt = {re_r[15:8], val_r[7:0]}; seq_nxt = S_IDLE; end
            S_WMAD: begin mad_nxt = val_r[7:2]; seq_nxt = S_IDLE; end
            S_WFMT: begin
              cfmt_nxt = val_r[6:4]; ifmt_nxt = val_r[2:0]; seq_nxt = S_IDLE;
            end
            S_MEMR: begin cc_nxt = adv_c; cr_nxt = adv_r; end
            S_MEMW: begin
              if (loc_cur[AddrW]) begin
                ram_we = 1'b1; ram_addr = loc_cur[AddrW-1:0]; ram_wdata = val_r;
                pw_nxt = 1'b1; pi_nxt = 17'(loc_cur[AddrW-1:0]); pc_nxt = val_r;
              end
              cc_nxt = adv_c; cr_nxt = adv_r;
            end
            default: ;
          endcase
        end
        ActDataRd: begin
          case (seq_r)
            S_ID1: seq_nxt = S_ID2;
            S_ID2: begin rd_nxt = {8'd0, id_r[23:16]}; seq_nxt = S_ID3; end
            S_ID3: begin rd_nxt = {8'd0, id_r[15:8]}; seq_nxt = S_ID4; end
            S_ID4: begin rd_nxt = {8'd0, id_r[7:0]}; seq_nxt = S_IDLE; end
            S_ST1: seq_nxt = S_ST2;
            S_ST2: begin rd_nxt = {9'd0, mad_r, 1'b0}; seq_nxt = S_ST3; end
            S_ST3: begin
              rd_nxt = {9'd0, ifmt_r, idm_r, ptl_r, slp_r, nor_r}; seq_nxt = S_ST4;
            end
            S_ST4: begin
              rd_nxt = {10'd0, inv_r, 2'b0, dis_r, te_r, 1'b0}; seq_nxt = S_ST5;
            end
            S_ST5: seq_nxt = S_IDLE;
            S_PWR1: seq_nxt = S_PWR2;
            S_PWR2: begin
              rd_nxt = {9'd0, idm_r, ptl_r, slp_r, nor_r, dis_r, 2'b0}; seq_nxt = S_IDLE;
            end
            S_MAD1: seq_nxt = S_MAD2;
            S_MAD2: begin rd_nxt = {8'd0, mad_r, 2'b0}; seq_nxt = S_IDLE; end
            S_FMT1: seq_nxt = S_FMT2;
            S_FMT2: begin rd_nxt = {9'd0, cfmt_r, 1'b0, ifmt_r}; seq_nxt = S_IDLE; end
            S_IMG1: seq_nxt = S_IMG2;
            S_IMG2: begin rd_nxt = {10'd0, inv_r, 5'd0}; seq_nxt = S_IDLE; end
            S_SIG1: seq_nxt = S_SIG2;
            S_SIG2: begin rd_nxt = {8'd0, te_r, 7'd0}; seq_nxt = S_IDLE; end
            S_DIAG1: seq_nxt = S_DIAG2;
            S_DIAG2: seq_nxt = S_IDLE;
            S_MEMR: begin
              // Read current pixel now, the advanced one (if any) next.
              rph_nxt  = ph_r;
              a_ok_nxt = loc_cur[AddrW];
              ram_addr = loc_cur[AddrW-1:0];
              b_ok_nxt = loc_adv[AddrW];
              b_idx_nxt = loc_adv[AddrW-1:0];
              if (ph_r == 2'd1) begin
                cc_nxt = adv_c; cr_nxt = adv_r; ph_nxt = 2'd2;
              end else if (ph_r == 2'd2) begin
                cc_nxt = adv_c; cr_nxt = adv_r; ph_nxt = 2'd0;
              end else begin
                ph_nxt = 2'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (cmd.rd1) begin
      ram_addr = b_idx_r;
    end
    if (cmd.rd2) begin
      // pa_r holds current pixel, ram_rdata the advanced one.
      case (rph_r)
        2'd1: rd_nxt = {(a_ok_r ? {pa_r[4:0], 3'b0} : 8'd0),
                        (b_ok_r ? {ram_rdata[15:11], 3'b0} : 8'd0)};
        2'd2: rd_nxt = a_ok_r ? {pa_r[10:5], 2'b0, pa_r[4:0], 3'b0} : 16'd0;
        default: rd_nxt = a_ok_r ? {pa_r[15:11], 3'b0, pa_r[10:5], 2'b0} : 16'd0;
      endcase
    end
  end

  // Register update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= DisplayIdReset;
      seq_r <= S_IDLE;
      slp_r <= 1'b0; ptl_r <= 1'b0; nor_r <= 1'b1; idm_r <= 1'b0;
      inv_r <= 1'b0; dis_r <= 1'b0; te_r <= 1'b0;
      mad_r <= '0; cfmt_r <= '0; ifmt_r <= 3'd6;
      cs_r <= '0; ce_r <= 16'(PanelWidth - 1);
      rs_r <= '0; re_r <= 16'(PanelHeight - 1);
      cc_r <= '0; cr_r <= '0; ph_r <= '0;
      clr_r <= '0;
    end else begin
      if (cfg_we) id_r <= cfg_wdata;
      if (cmd.clr_step && !sts.clr_done) clr_r <= clr_r + AddrW'(1);
      if (cmd.exec) begin
        seq_r <= seq_nxt; slp_r <= slp_nxt; ptl_r <= ptl_nxt; nor_r <= nor_nxt;
        idm_r <= idm_nxt; inv_r <= inv_nxt; dis_r <= dis_nxt; te_r <= te_nxt;
        mad_r <= mad_nxt; cfmt_r <= cfmt_nxt; ifmt_r <= ifmt_nxt;
        cs_r <= cs_nxt; ce_r <= ce_nxt; rs_r <= rs_nxt; re_r <= re_nxt;
        cc_r <= cc_nxt; cr_r <= cr_nxt; ph_r <= ph_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      val_r <= in_data_value;
    end
    if (cmd.exec) begin
      rd_r <= rd_nxt; pw_r <= pw_nxt; pi_r <= pi_nxt; pc_r <= pc_nxt;
      a_ok_r <= a_ok_nxt; b_ok_r <= b_ok_nxt; b_idx_r <= b_idx_nxt; rph_r <= rph_nxt;
    end
    if (cmd.rd1) pa_r <= ram_rdata;
    if (cmd.rd2) rd_r <= rd_nxt;
  end

  assign out_read_data     = rd_r;
  assign out_pixel_written = pw_r;
  assign out_pixel_index   = pi_r;
  assign out_pixel_color   = pc_r;

endmodule

[design/lcd_command_frame_memory_controller_core.sv]
// Top level of the LCD command and frame memory controller.
// Uses lcdc_pkg, lcdc_ctrl and lcdc_dp.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_action, in_data_value
// out      output     out_valid / out_stall  out_read_data, out_pixel_*
// cfg      input      cfg_we                 cfg_wdata (display ID)
//
// Each item passes capture, execute and present; a memory data read adds rd1
// and rd2, since the single-port frame RAM is read once for each pixel touched.
// After reset a clearing pass zeroes the 76800-entry frame RAM, one entry a
// cycle, and no item is accepted during it. A result waits in its output
// register while out_stall is high, and the next item waits behind it.
`timescale 1ns / 1ps
module lcd_command_frame_memory_controller_core
  import lcdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_data_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_pixel_written,
  output logic [16:0] out_pixel_index,
  output logic [15:0] out_pixel_color
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lcdc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  lcdc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_action(in_action), .in_data_value(in_data_value), .cmd(cmd), .sts(sts),
    .out_read_data(out_read_data), .out_pixel_written(out_pixel_written),
    .out_pixel_index(out_pixel_index), .out_pixel_color(out_pixel_color)
  );

endmodule

[bench/lcdc_result_checker.sv]
// Result checker for the LCD command and frame memory controller bench.
// Watches the config port and both channels, predicts each result and compares.
// Depends on lcdc_pkg for command codes, bus actions and sequencer states.
`timescale 1ns / 1ps
module lcdc_result_checker
  import lcdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_data_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_read_data,
  input  logic        out_pixel_written,
  input  logic [16:0] out_pixel_index,
  input  logic [15:0] out_pixel_color,
  output int          error_count,
  output int          pending_count
);

  typedef struct packed {
    logic [15:0] read_data;
    logic        pixel_written;
    logic [16:0] pixel_index;
    logic [15:0] pixel_color;
  } bus_result_t;

  bus_result_t predicted_results[$];

  // Shadow copy of the controller state.
  logic [23:0] id_value;
  seq_state_t  seq;
  logic        slp_out, ptl_on, nor_on, idm_on, inv_on, dis_on, te_on;
  logic [5:0]  madctl;
  logic [2:0]  color_fmt, iface_fmt;
  logic [15:0] col_lo, col_hi, row_lo, row_hi, cur_col, cur_row;
  logic [1:0]  rd_phase;
  logic [15:0] frame_store [FrameSize];

  // Clears mode flags and opens the window to the full panel.
  function automatic void soft_reset_flags();
    slp_out = 0; ptl_on = 0; nor_on = 1; idm_on = 0;
    inv_on = 0; dis_on = 0; te_on = 0;
    col_lo = 0;
    row_lo = 0;
    if (madctl[3]) begin
      col_hi = 16'(PanelHeight - 1);
      row_hi = 16'(PanelWidth - 1);
    end else begin
      col_hi = 16'(PanelWidth - 1);
      row_hi = 16'(PanelHeight - 1);
    end
  endfunction

  // Maps the cursor through the orientation bits to a frame address.
  function automatic logic cursor_address(output int unsigned addr);
    int c, r, x, y;
    c = int'(cur_col);
    r = int'(cur_row);
    if (madctl[3]) begin
      x = madctl[5] ? r : (PanelWidth - 1) - r;
      y = madctl[4] ? c : (PanelHeight - 1) - c;
    end else begin
      x = madctl[4] ? (PanelWidth - 1) - c : c;
      y = madctl[5] ? (PanelHeight - 1) - r : r;
    end
    addr = 0;
    if (x < 0 || x >= PanelWidth || y < 0 || y >= PanelHeight) return 0;
    addr = y * PanelWidth + x;
    return 1;
  endfunction

  // Steps the cursor, wrapping the column and then the row inside the window.
  function automatic void step_cursor();
    if ({1'b0, cur_col} + 17'd1 > {1'b0, col_hi}) begin
      cur_col = col_lo;
      if ({1'b0, cur_row} + 17'd1 > {1'b0, row_hi}) cur_row = row_lo;
      else cur_row = cur_row + 16'd1;
    end else begin
      cur_col = cur_col + 16'd1;
    end
  endfunction

  // Colour byte of the pixel under the cursor: 0 red, 1 green, 2 blue.
  function automatic logic [7:0] colour_byte(int sel);
    int unsigned addr;
    logic [15:0] p;
    if (!cursor_address(addr)) return 8'h00;
    p = frame_store[addr];
    if (sel == 0) return p[15:8] & 8'hF8;
    if (sel == 1) return p[10:3] & 8'hFC;
    return {p[4:0], 3'b000};
  endfunction

  function automatic void run_command(logic [15:0] v);
    case (v)
      CmdSwReset: begin soft_reset_flags(); seq = S_IDLE; end
      CmdRdId:   seq = S_ID1;
      CmdRdSt:   seq = S_ST1;
      CmdRdPwr:  seq = S_PWR1;
      CmdRdMad:  seq = S_MAD1;
      CmdRdFmt:  seq = S_FMT1;
      CmdRdImg:  seq = S_IMG1;
      CmdRdSig:  seq = S_SIG1;
      CmdRdDiag: seq = S_DIAG1;
      CmdSlpIn:  slp_out = 0;
      CmdSlpOut: slp_out = 1;
      CmdPtlOn:  begin ptl_on = 1; nor_on = 0; end
      CmdNorOn:  begin nor_on = 1; ptl_on = 0; end
      CmdInvOff: inv_on = 0;
      CmdInvOn:  inv_on = 1;
      CmdDispOff: dis_on = 0;
      CmdDispOn: dis_on = 1;
      CmdCaSet:  seq = S_COL1;
      CmdRaSet:  seq = S_ROW1;
      CmdRamWr: begin
        seq = S_MEMW; cur_col = col_lo; cur_row = row_lo;
      end
      CmdRamRd: begin
        seq = S_MEMR; cur_col = col_lo; cur_row = row_lo; rd_phase = 0;
      end
      CmdTeOff:  te_on = 0;
      CmdTeOn:   te_on = 1;
      CmdMadCtl: seq = S_WMAD;
      CmdIdmOff: idm_on = 0;
      CmdIdmOn:  idm_on = 1;
      CmdColMod: seq = S_WFMT;
      default: ;
    endcase
  endfunction

  function automatic void run_data_write(logic [15:0] v, inout bus_result_t res);
    logic [7:0] lo;
    int unsigned addr;
    lo = v[7:0];
    case (seq)
      S_COL1: begin col_lo[15:8] = lo; seq = S_COL2; end
      S_COL2: begin col_lo[7:0] = lo; seq = S_COL3; end
      S_COL3: begin col_hi[15:8] = lo; seq = S_COL4; end
      S_COL4: begin col_hi[7:0] = lo; seq = S_IDLE; end
      S_ROW1: begin row_lo[15:8] = lo; seq = S_ROW2; end
      S_ROW2: begin row_lo[7:0] = lo; seq = S_ROW3; end
      S_ROW3: begin row_hi[15:8] = lo; seq = S_ROW4; end
      S_ROW4: begin row_hi[7:0] = lo; seq = S_IDLE; end
      S_WMAD: begin madctl = lo[7:2]; seq = S_IDLE; end
      S_WFMT: begin
        color_fmt = lo[6:4]; iface_fmt = lo[2:0]; seq = S_IDLE;
      end
      S_MEMR: step_cursor();
      S_MEMW: begin
        if (cursor_address(addr)) begin
          frame_store[addr] = v;
          res.pixel_written = 1;
          res.pixel_index = addr[16:0];
          res.pixel_color = v;
        end
        step_cursor();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] run_data_read();
    logic [15:0] v;
    v = 0;
    case (seq)
      S_ID1: seq = S_ID2;
      S_ID2: begin v = {8'd0, id_value[23:16]}; seq = S_ID3; end
      S_ID3: begin v = {8'd0, id_value[15:8]}; seq = S_ID4; end
      S_ID4: begin v = {8'd0, id_value[7:0]}; seq = S_IDLE; end
      S_ST1: seq = S_ST2;
      S_ST2: begin v = {9'd0, madctl, 1'b0}; seq = S_ST3; end
      S_ST3: begin
        v = {9'd0, iface_fmt, idm_on, ptl_on, slp_out, nor_on}; seq = S_ST4;
      end
      S_ST4: begin v = {10'd0, inv_on, 2'b00, dis_on, te_on, 1'b0}; seq = S_ST5; end
      S_ST5: seq = S_IDLE;
      S_PWR1: seq = S_PWR2;
      S_PWR2: begin
        v = {9'd0, idm_on, ptl_on, slp_out, nor_on, dis_on, 2'b00}; seq = S_IDLE;
      end
      S_MAD1: seq = S_MAD2;
      S_MAD2: begin v = {8'd0, madctl, 2'b00}; seq = S_IDLE; end
      S_FMT1: seq = S_FMT2;
      S_FMT2: begin v = {9'd0, color_fmt, 1'b0, iface_fmt}; seq = S_IDLE; end
      S_IMG1: seq = S_IMG2;
      S_IMG2: begin v = {10'd0, inv_on, 5'b0}; seq = S_IDLE; end
      S_SIG1: seq = S_SIG2;
      S_SIG2: begin v = {8'd0, te_on, 7'b0}; seq = S_IDLE; end
      S_DIAG1: seq = S_DIAG2;
      S_DIAG2: seq = S_IDLE;
      // Two pixels are returned as six colour bytes over three reads.
      S_MEMR: begin
        if (rd_phase == 1) begin
          v[15:8] = colour_byte(2);
          step_cursor();
          v[7:0] = colour_byte(0);
          rd_phase = 2;
        end else if (rd_phase == 2) begin
          v = {colour_byte(1), colour_byte(2)};
          rd_phase = 0;
          step_cursor();
        end else begin
          v = {colour_byte(0), colour_byte(1)};
          rd_phase = 1;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // Predicts the result of one bus access and updates the shadow state.
  function automatic bus_result_t bus_access(logic [1:0] action, logic [15:0] v);
    bus_result_t res;
    res = '0;
    if (action == ActCmdWr) run_command(v);
    else if (action == ActDataWr) run_data_write(v, res);
    else if (action == ActDataRd) res.read_data = run_data_read();
    return res;
  endfunction

  // Track accepted items and compare each result with the oldest prediction.
  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      id_value = DisplayIdReset;
      seq = S_IDLE;
      madctl = 0;
      color_fmt = 0;
      iface_fmt = 6;
      soft_reset_flags();
      cur_col = 0;
      cur_row = 0;
      rd_phase = 0;
      for (int i = 0; i < FrameSize; i++) frame_store[i] = 0;
      predicted_results.delete();
      error_count <= 0;
    end else begin
      if (cfg_we) id_value = cfg_wdata;
      if (in_valid && !in_stall)
        predicted_results.push_back(bus_access(in_action, in_data_value));
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected: rd %h pw %b idx %0d col %h",
                   $time, out_read_data, out_pixel_written, out_pixel_index,
                   out_pixel_color);
          error_count <= error_count + 1;
        end else begin
          want = predicted_results.pop_front();
          if (want.read_data !== out_read_data)
            $display("%0t: read_data expected %h actual %h",
                     $time, want.read_data, out_read_data);
          if (want.pixel_written !== out_pixel_written)
            $display("%0t: pixel_written expected %b actual %b",
                     $time, want.pixel_written, out_pixel_written);
          if (want.pixel_index !== out_pixel_index)
            $display("%0t: pixel_index expected %0d actual %0d",
                     $time, want.pixel_index, out_pixel_index);
          if (want.pixel_color !== out_pixel_color)
            $display("%0t: pixel_color expected %h actual %h",
                     $time, want.pixel_color, out_pixel_color);
          if (want !== {out_read_data, out_pixel_written, out_pixel_index,
                        out_pixel_color})
            error_count <= error_count + 1;
        end
      end
    end
    pending_count <= predicted_results.size();
  end

endmodule

[bench/lcd_command_frame_memory_controller_core_tb.sv]
// Top of the LCD command and frame memory controller bench.
// Drives bus items and display ID writes; uses lcdc_pkg and lcdc_result_checker.
`timescale 1ns / 1ps
module lcd_command_frame_memory_controller_core_tb;
  import lcdc_pkg::*;

  localparam int CycleLimit = 1000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [15:0] in_data_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_read_data;
  logic        out_pixel_written;
  logic [16:0] out_pixel_index;
  logic [15:0] out_pixel_color;
  int          error_count;
  int          pending_count;
  int          cycle_count;
  int          items_sent;
  logic        no_gaps;

  lcd_command_frame_memory_controller_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_data_value(in_data_value), .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_pixel_written(out_pixel_written),
    .out_pixel_index(out_pixel_index), .out_pixel_color(out_pixel_color)
  );

  lcdc_result_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_data_value(in_data_value), .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_pixel_written(out_pixel_written),
    .out_pixel_index(out_pixel_index), .out_pixel_color(out_pixel_color),
    .error_count(error_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Timeout guard.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("lcd_command_frame_memory_controller_core_tb: errors");
      $finish;
    end
  end

  // Result side: a random stall before each item, none during bursts.
  initial begin
    int hold;
    out_stall <= 0;
    @(posedge rst_n);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Sends one bus item after a random gap and waits until it is taken.
  task automatic send_item(logic [1:0] action, logic [15:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= action;
    in_data_value <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Waits until every result is back, then writes the display ID.
  task automatic write_display_id(logic [23:0] value);
    in_valid <= 0;
    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Loads a column or row window with the given limits, junk in the high byte.
  task automatic load_window(logic [15:0] cmd, logic [15:0] lo, logic [15:0] hi);
    send_item(ActCmdWr, cmd);
    send_item(ActDataWr, {8'($urandom), lo[15:8]});
    send_item(ActDataWr, {8'($urandom), lo[7:0]});
    send_item(ActDataWr, {8'($urandom), hi[15:8]});
    send_item(ActDataWr, {8'($urandom), hi[7:0]});
  endtask

  function automatic logic [15:0] window_edge();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 7));
      1: return 16'($urandom_range(230, 330));
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 320));
    endcase
  endfunction

  // One random sequence: mostly well formed, with some noise mixed in.
  task automatic random_sequence();
    logic [15:0] reg_reads[8];
    logic [15:0] flags[15];
    logic [15:0] lo, hi;
    int n;
    reg_reads = '{CmdRdId, CmdRdSt, CmdRdPwr, CmdRdMad, CmdRdFmt, CmdRdImg,
                  CmdRdSig, CmdRdDiag};
    flags = '{CmdSwReset, CmdSlpIn, CmdSlpOut, CmdPtlOn, CmdNorOn, CmdInvOff,
              CmdInvOn, CmdDispOff, CmdDispOn, CmdTeOff, CmdTeOn, CmdIdmOff,
              CmdIdmOn, CmdSlpOut, CmdDispOn};
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(0, 7);
        send_item(ActCmdWr, reg_reads[n]);
        n = (n == 0) ? 4 : (n == 1) ? 5 : 2;
        repeat (n + $urandom_range(0, 1) - $urandom_range(0, 1))
          send_item(ActDataRd, 16'($urandom));
      end
      1: send_item(ActCmdWr, flags[$urandom_range(0, 14)]);
      2, 3: begin
        lo = window_edge();
        hi = ($urandom_range(0, 4) == 0) ? window_edge() : lo + $urandom_range(0, 4);
        load_window($urandom_range(0, 1) ? CmdCaSet : CmdRaSet, lo, hi);
      end
      4: begin
        send_item(ActCmdWr, CmdMadCtl);
        send_item(ActDataWr, 16'($urandom));
      end
      5: begin
        send_item(ActCmdWr, CmdColMod);
        send_item(ActDataWr, 16'($urandom));
      end
      6, 7: begin
        send_item(ActCmdWr, CmdRamWr);
        repeat ($urandom_range(1, 8)) send_item(ActDataWr, 16'($urandom));
      end
      8: begin
        send_item(ActCmdWr, CmdRamRd);
        repeat ($urandom_range(1, 9))
          send_item($urandom_range(0, 5) == 0 ? ActDataWr : ActDataRd, 16'($urandom));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n)
          send_item(2'($urandom),
                    $urandom_range(0, 1) ? 16'($urandom_range(0, 63)) : 16'($urandom));
      end
    endcase
  endtask

  // Stimulus: directed corner items, then random sequences in phases.
  initial begin
    in_valid <= 0;
    in_action <= ActCmdWr;
    in_data_value <= 0;
    cfg_we <= 0;
    cfg_wdata <= 0;
    rst_n <= 0;
    no_gaps = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Reset ID, idle reads and an unknown command.
    send_item(ActCmdRd, 16'hFFFF);
    send_item(ActDataRd, 16'hFFFF);
    send_item(ActDataWr, 16'hFFFF);
    send_item(ActCmdWr, 16'hFF00);
    send_item(ActCmdWr, CmdRdId);
    repeat (4) send_item(ActDataRd, 16'h0000);
    // Bottom right pixel of the panel, written then read back.
    load_window(CmdCaSet, 16'h00EF, 16'h00EF);
    load_window(CmdRaSet, 16'h013F, 16'h013F);
    send_item(ActCmdWr, CmdRamWr);
    send_item(ActDataWr, 16'hFFFF);
    send_item(ActCmdWr, CmdRamRd);
    repeat (3) send_item(ActDataRd, 16'h0000);
    // All orientation bits, then software reset with the axes swapped.
    send_item(ActCmdWr, CmdMadCtl);
    send_item(ActDataWr, 16'h00FC);
    send_item(ActCmdWr, CmdSwReset);

    write_display_id(24'hFFFFFF);
    while (items_sent < 425) begin
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      random_sequence();
      if (items_sent >= 160 && items_sent < 180) write_display_id(24'h000000);
      if (items_sent >= 300 && items_sent < 320) write_display_id(24'($urandom));
    end
    in_valid <= 0;

    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("lcd_command_frame_memory_controller_core_tb: clean");
    else
      $display("lcd_command_frame_memory_controller_core_tb: errors");
    $finish;
  end

endmodule
